/* rtl/wpbd_pkg.sv */
package wpbd_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int SAMPLE_BITS  = 14;
   localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
   localparam int PCT_INV      = 20;

   // sorted positions of the window statistics
   localparam int IDX_LOW  = WINDOW_DEPTH / PCT_INV;
   localparam int IDX_MID  = WINDOW_DEPTH / 2;
   localparam int IDX_HIGH = WINDOW_DEPTH - WINDOW_DEPTH / PCT_INV;
   localparam int IDX_MAX  = WINDOW_DEPTH - 1;

   // configuration register indexes
   localparam logic [1:0] REG_SILENCE = 2'd0;
   localparam logic [1:0] REG_DELAY   = 2'd1;
   localparam logic [1:0] REG_MODE    = 2'd2;
   localparam logic [1:0] REG_START   = 2'd3;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] mic_sample;
      logic [31:0]            time_ms;
   } req_type;

   typedef struct packed {
      logic                   beat;
      logic                   led_write;
      logic [7:0]             led_level;
      logic [4:0]             fade_now;
      logic [SAMPLE_BITS-1:0] window_min;
      logic [SAMPLE_BITS-1:0] window_low;
      logic [SAMPLE_BITS-1:0] window_mid;
      logic [SAMPLE_BITS-1:0] window_high;
      logic [SAMPLE_BITS-1:0] window_max;
   } rsp_type;

   typedef struct packed {
      logic       wr;
      logic [7:0] level;
      logic [4:0] delay;
   } fade_entry_type;

   // sorted address of statistic number s (min, low, mid, high, max)
   function automatic logic [ADDR_BITS-1:0] stat_addr(input logic [2:0] s);
      logic [ADDR_BITS-1:0] a;
      case (s)
         3'd0:    a = '0;
         3'd1:    a = ADDR_BITS'(IDX_LOW);
         3'd2:    a = ADDR_BITS'(IDX_MID);
         3'd3:    a = ADDR_BITS'(IDX_HIGH);
         default: a = ADDR_BITS'(IDX_MAX);
      endcase
      return a;
   endfunction

   // brightness (already scaled by 190/255) and delay for a fade level
   function automatic fade_entry_type fade_entry(input logic mode, input logic [4:0] lvl);
      fade_entry_type e;
      e = '{wr: 1'b1, level: 8'd0, delay: 5'd0};
      if (mode) begin
         case (lvl)
            5'd2:    e = '{wr: 1'b1, level: 8'd190, delay: 5'd16};
            5'd1:    e = '{wr: 1'b1, level: 8'd3, delay: 5'd16};
            default: e = '{wr: 1'b0, level: 8'd0, delay: 5'd0};
         endcase
      end else begin
         case (lvl)
            5'd1:    e = '{wr: 1'b1, level: 8'd3,   delay: 5'd1};
            5'd2:    e = '{wr: 1'b1, level: 8'd7,   delay: 5'd3};
            5'd3:    e = '{wr: 1'b1, level: 8'd14,  delay: 5'd3};
            5'd4:    e = '{wr: 1'b1, level: 8'd22,  delay: 5'd3};
            5'd5:    e = '{wr: 1'b1, level: 8'd29,  delay: 5'd3};
            5'd6:    e = '{wr: 1'b1, level: 8'd37,  delay: 5'd3};
            5'd7:    e = '{wr: 1'b1, level: 8'd44,  delay: 5'd3};
            5'd8:    e = '{wr: 1'b1, level: 8'd52,  delay: 5'd3};
            5'd9:    e = '{wr: 1'b1, level: 8'd59,  delay: 5'd5};
            5'd10:   e = '{wr: 1'b1, level: 8'd67,  delay: 5'd5};
            5'd11:   e = '{wr: 1'b1, level: 8'd74,  delay: 5'd5};
            5'd12:   e = '{wr: 1'b1, level: 8'd81,  delay: 5'd5};
            5'd13:   e = '{wr: 1'b1, level: 8'd89,  delay: 5'd6};
            5'd14:   e = '{wr: 1'b1, level: 8'd96,  delay: 5'd5};
            5'd15:   e = '{wr: 1'b1, level: 8'd104, delay: 5'd5};
            5'd16:   e = '{wr: 1'b1, level: 8'd111, delay: 5'd4};
            5'd17:   e = '{wr: 1'b1, level: 8'd119, delay: 5'd3};
            5'd18:   e = '{wr: 1'b1, level: 8'd126, delay: 5'd2};
            5'd19:   e = '{wr: 1'b1, level: 8'd134, delay: 5'd3};
            5'd20:   e = '{wr: 1'b1, level: 8'd141, delay: 5'd3};
            5'd21:   e = '{wr: 1'b1, level: 8'd149, delay: 5'd3};
            5'd22:   e = '{wr: 1'b1, level: 8'd156, delay: 5'd3};
            5'd23:   e = '{wr: 1'b1, level: 8'd163, delay: 5'd2};
            5'd24:   e = '{wr: 1'b1, level: 8'd171, delay: 5'd2};
            5'd25:   e = '{wr: 1'b1, level: 8'd178, delay: 5'd2};
            5'd26:   e = '{wr: 1'b1, level: 8'd186, delay: 5'd2};
            5'd27:   e = '{wr: 1'b1, level: 8'd190, delay: 5'd2};
            default: e = '{wr: 1'b0, level: 8'd0, delay: 5'd0};
         endcase
      end
      return e;
   endfunction

endpackage

/* rtl/wpbd_ram.sv */
module wpbd_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* rtl/window_percentile_beat_detector_top.sv */
// Beat detector over a sliding window of microphone samples.
// Request channel (req_valid/req_ready/req_data) takes one sample and the
// current millisecond time; response channel (rsp_valid/rsp_ready/rsp_data)
// returns one result per request: beat flag, LED write and level, fade level
// and the window minimum, low percentile, median, high percentile, maximum.
// The csr_ port writes the four settings at any edge with csr_we high.
// The window is kept twice: a ring of raw samples and a sorted copy, each in
// a one-port-read, one-port-write RAM. A request reads five sorted entries
// and returns its result. Every second request then stores its sample: the
// evicted value is removed and the new one inserted in one pass over the
// sorted RAM, entry by entry, and the next request is accepted only when
// that pass is done; the other requests go back to idle after their result.
// Reset clears both RAMs in one pass, during which req_ready is low.
// The result sits in an output register; when the receiver stalls, the next
// request is still taken and its statistics read, and it waits only to load
// its own result until the previous one has been taken.
module window_percentile_beat_detector_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wpbd_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wpbd_pkg::rsp_type     rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   import wpbd_pkg::*;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_STAT   = 4'd2;
   localparam logic [3:0] ST_DECIDE = 4'd3;
   localparam logic [3:0] ST_RING   = 4'd4;
   localparam logic [3:0] ST_PRE    = 4'd5;
   localparam logic [3:0] ST_SRD    = 4'd6;
   localparam logic [3:0] ST_SEV    = 4'd7;

   localparam logic [ADDR_BITS-1:0] LAST = ADDR_BITS'(WINDOW_DEPTH - 1);

   logic [3:0]             state_ff, state_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;
   logic [2:0]             stat_ff, stat_in;
   logic [SAMPLE_BITS-1:0] win_ff [5];
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [31:0]            time_ff;

   logic [13:0]            thr_ff;
   logic [15:0]            min_delay_ff;
   logic                   mode_ff;
   logic [4:0]             start_ff;

   logic [ADDR_BITS-1:0]   slot_ff, slot_in;
   logic                   toggle_ff, toggle_in;
   logic [31:0]            beat_dl_ff, beat_dl_in;
   logic [31:0]            blink_dl_ff, blink_dl_in;
   logic [4:0]             fade_ff, fade_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [SAMPLE_BITS-1:0] old_ff, old_in;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic                   up_ff, up_in;
   logic                   found_ff, found_in;
   logic [ADDR_BITS-1:0]   t_ff, t_in;

   logic                   ring_we;
   logic [ADDR_BITS-1:0]   ring_waddr, ring_raddr;
   logic [SAMPLE_BITS-1:0] ring_wdata, ring_rdata;
   logic                   sort_we;
   logic [ADDR_BITS-1:0]   sort_waddr, sort_raddr;
   logic [SAMPLE_BITS-1:0] sort_wdata, sort_rdata;

   logic                   beat_hit, blink_due, out_free, at_end, shift_ok;
   logic [4:0]             lvl;
   fade_entry_type         entry;
   logic [ADDR_BITS-1:0]   t_step;

   wpbd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   wpbd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_sorted (
      .clock (clock),
      .we    (sort_we),
      .waddr (sort_waddr),
      .wdata (sort_wdata),
      .raddr (sort_raddr),
      .rdata (sort_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // beat and fade decision from the captured statistics
   always_comb begin
      beat_hit = ((sample_ff > win_ff[3]) || (sample_ff < win_ff[1])) &&
                 ((win_ff[3] - win_ff[1]) > thr_ff) && (time_ff > beat_dl_ff);
      lvl       = beat_hit ? start_ff : fade_ff;
      blink_due = (lvl != 5'd0) && (time_ff >= blink_dl_ff);
      entry     = fade_entry(mode_ff, lvl);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign at_end   = up_ff ? (t_ff == LAST) : (t_ff == '0);
   assign t_step   = up_ff ? t_ff + 1'b1 : t_ff - 1'b1;
   assign shift_ok = !at_end && (up_ff ? (sort_rdata <= sample_ff) : (sort_rdata > sample_ff));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      stat_in      = stat_ff;
      slot_in      = slot_ff;
      toggle_in    = toggle_ff;
      beat_dl_in   = beat_dl_ff;
      blink_dl_in  = blink_dl_ff;
      fade_in      = fade_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      old_in       = old_ff;
      prev_in      = prev_ff;
      up_in        = up_ff;
      found_in     = found_ff;
      t_in         = t_ff;
      ring_we      = 1'b0;
      ring_waddr   = slot_ff;
      ring_wdata   = sample_ff;
      ring_raddr   = slot_ff;
      sort_we      = 1'b0;
      sort_waddr   = t_ff;
      sort_wdata   = sample_ff;
      sort_raddr   = stat_addr(stat_ff);

      case (state_ff)
         ST_CLEAR: begin
            ring_we    = 1'b1;
            ring_waddr = clr_ff;
            ring_wdata = '0;
            sort_we    = 1'b1;
            sort_waddr = clr_ff;
            sort_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            stat_in = '0;
            if (req_valid) begin
               state_in = ST_STAT;
            end
         end
         ST_STAT: begin
            // issue one address per cycle, data for the previous lands here
            stat_in = stat_ff + 1'b1;
            if (stat_ff == 3'd5) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.beat         = beat_hit;
               rsp_in.led_write    = blink_due && entry.wr;
               rsp_in.led_level    = (blink_due && entry.wr) ? entry.level : 8'd0;
               rsp_in.window_min   = win_ff[0];
               rsp_in.window_low   = win_ff[1];
               rsp_in.window_mid   = win_ff[2];
               rsp_in.window_high  = win_ff[3];
               rsp_in.window_max   = win_ff[4];
               if (beat_hit) begin
                  beat_dl_in = time_ff + {16'd0, min_delay_ff};
               end
               if (blink_due) begin
                  fade_in = lvl - 1'b1;
                  if (entry.wr) begin
                     blink_dl_in = time_ff + {27'd0, entry.delay};
                  end
               end else begin
                  fade_in = lvl;
               end
               rsp_in.fade_now = blink_due ? lvl - 1'b1 : lvl;
               toggle_in       = !toggle_ff;
               if (!toggle_ff) begin
                  slot_in    = slot_ff + 1'b1;
                  ring_raddr = slot_ff + 1'b1;
                  state_in   = ST_RING;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RING: begin
            // evict the old ring entry, store the new sample
            ring_we    = 1'b1;
            old_in     = ring_rdata;
            up_in      = (sample_ff >= ring_rdata);
            found_in   = 1'b0;
            t_in       = (sample_ff >= ring_rdata) ? '0 : LAST;
            sort_raddr = (sample_ff >= ring_rdata) ? '0 : LAST;
            state_in   = ST_PRE;
         end
         ST_PRE: begin
            prev_in  = sort_rdata;
            state_in = ST_SRD;
         end
         ST_SRD: begin
            sort_raddr = t_step;
            state_in   = ST_SEV;
         end
         ST_SEV: begin
            // remove one copy of the old value, shift, then insert the new one
            if (!found_ff && (prev_ff != old_ff)) begin
               prev_in  = sort_rdata;
               t_in     = t_step;
               state_in = at_end ? ST_IDLE : ST_SRD;
            end else begin
               found_in = 1'b1;
               sort_we  = 1'b1;
               if (shift_ok) begin
                  sort_wdata = sort_rdata;
                  prev_in    = sort_rdata;
                  t_in       = t_step;
                  state_in   = ST_SRD;
               end else begin
                  sort_wdata = sample_ff;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         stat_ff      <= '0;
         slot_ff      <= '0;
         toggle_ff    <= 1'b0;
         beat_dl_ff   <= '0;
         blink_dl_ff  <= '0;
         fade_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         up_ff        <= 1'b0;
         t_ff         <= '0;
         thr_ff       <= 14'd50;
         min_delay_ff <= 16'd100;
         mode_ff      <= 1'b0;
         start_ff     <= 5'd27;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         stat_ff      <= stat_in;
         slot_ff      <= slot_in;
         toggle_ff    <= toggle_in;
         beat_dl_ff   <= beat_dl_in;
         blink_dl_ff  <= blink_dl_in;
         fade_ff      <= fade_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         up_ff        <= up_in;
         t_ff         <= t_in;
         if (csr_we) begin
            case (csr_index)
               REG_SILENCE: thr_ff       <= csr_wdata[13:0];
               REG_DELAY:   min_delay_ff <= csr_wdata;
               REG_MODE:    mode_ff      <= csr_wdata[0];
               REG_START:   start_ff     <= csr_wdata[4:0];
               default:     thr_ff       <= thr_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      old_ff  <= old_in;
      prev_ff <= prev_in;
      if (req_valid && req_ready) begin
         sample_ff <= req_data.mic_sample;
         time_ff   <= req_data.time_ms;
      end
      if ((state_ff == ST_STAT) && (stat_ff != 3'd0)) begin
         win_ff[stat_ff - 1'b1] <= sort_rdata;
      end
   end

endmodule
